FILE: rtl/lbvm_pkg.sv
// Shared types, constants and helpers for the linear battery voltage model.
package lbvm_pkg;

    localparam int LBVM_MAX_LOADS = 256;

    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W    = 40;
    localparam int FRAC_W   = 16;
    localparam int DIV_BITS = SUM_W + FRAC_W;
    localparam int DCNT_W   = $clog2(DIV_BITS + 1);
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 52;
    localparam int WIDE_W   = 68;
    localparam int NEAR_ZERO = 65;

    localparam int NUM_STEPS = 16;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OCV_CONST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCV_LINEAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_RECIP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES_RES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CHARGE = 3'd6;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_F_UPD,
        OP_Q_UPD,
        OP_D,
        OP_T1,
        OP_OUT,
        OP_OUT_ZERO
    } t_op;

    // multiplier operand pair
    typedef enum logic [2:0] {
        MS_NONE,
        MS_KDIFF,
        MS_CSF,
        MS_QCAP,
        MS_E1D,
        MS_RF
    } t_msel;

    // sequencing condition
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_START,
        COND_NEARZ,
        COND_DIV,
        COND_OUT_WAIT,
        COND_JUMP
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_msel             msel;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        logic  fire;
    } t_ctrl;

    typedef struct packed {
        logic near_zero;
        logic div_last;
    } t_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > WIDE_W'(64'sd2147483647)) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -WIDE_W'(64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/linear_battery_voltage_model_core.sv
// Top level: config registers, load summing, output register, sequencer and datapath.
// A load that is not last is only summed. The last load starts the microprogram: 56
//   divider steps plus 12 other microcode steps, or the init and zero-output steps
//   for a near-zero bus voltage; result-side stalls hold the output step.
// Throughput: one load per cycle within an update; none while an update runs.
// Reset (synchronous, active low): config registers, load sum, filter and charge go to zero.
module linear_battery_voltage_model_core import lbvm_pkg::*; #(
    parameter int MAX_LOADS = LBVM_MAX_LOADS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // load stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // bus_voltage [31:0], load_power [63:32]
    input  logic                 s_axis_tlast,  // last_load
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [95:0]          m_axis_tdata   // out_voltage, charge_left, smoothed_current
);

    localparam int CNT_W = $clog2(MAX_LOADS + 1);

    // configuration registers
    logic signed [DATA_W-1:0] r_ocv_const;
    logic signed [DATA_W-1:0] r_ocv_linear;
    logic [DATA_W-2:0]        r_cap_recip;
    logic [DATA_W-2:0]        r_series_res;
    logic [FRAC_W:0]          r_smooth_gain;
    logic [DATA_W-1:0]        r_charge_step;
    logic                     q_load;

    // load summing
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [SUM_W-1:0]  r_total;
    logic signed [DATA_W-1:0] r_volt;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     take;
    logic                     in_xfer;
    logic                     start;

    // sequencer and datapath
    t_ctrl                    ctrl;
    t_stat                    stat;
    logic                     seq_idle;
    logic                     out_free;
    logic                     out_load;
    logic signed [DATA_W-1:0] dp_voltage;
    logic signed [DATA_W-1:0] dp_charge;
    logic signed [DATA_W-1:0] dp_current;

    // output register
    logic                     r_out_valid;
    logic [95:0]              r_out_data;

    // Config: one register per enabled edge; host must write only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocv_const   <= '0;
            r_ocv_linear  <= '0;
            r_cap_recip   <= '0;
            r_series_res  <= '0;
            r_smooth_gain <= '0;
            r_charge_step <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OCV_CONST:   r_ocv_const   <= i_cfg_data;
                CFG_OCV_LINEAR:  r_ocv_linear  <= i_cfg_data;
                CFG_CAP_RECIP:   r_cap_recip   <= i_cfg_data[DATA_W-2:0];
                CFG_SERIES_RES:  r_series_res  <= i_cfg_data[DATA_W-2:0];
                CFG_SMOOTH_GAIN: r_smooth_gain <= i_cfg_data[FRAC_W:0];
                CFG_CHARGE_STEP: r_charge_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Writing the initial charge also reloads the stored charge.
    assign q_load = i_cfg_we && (i_cfg_idx == CFG_INIT_CHARGE);

    // Accept loads only while the sequencer waits at its first step.
    assign s_axis_tready = seq_idle;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign start         = in_xfer && s_axis_tlast;

    // Saturating sum; loads beyond the limit of one update are dropped.
    assign take     = (r_cnt < CNT_W'(MAX_LOADS));
    assign sum_wide = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'($signed(s_axis_tdata[63:32]));

    always_comb begin
        if (sum_wide > (SUM_W + 1)'(64'sh7F_FFFF_FFFF)) begin
            sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end else if (sum_wide < -(SUM_W + 1)'(64'sh80_0000_0000)) begin
            sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign sum_next = take ? sum_sat : r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (in_xfer) begin
            if (s_axis_tlast) begin
                // close the update: hand the total over and clear the sum
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= sum_next;
                r_cnt <= r_cnt + CNT_W'(take);
            end
        end
    end

    // Operands of the update; held steady while the microprogram runs.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_total <= sum_next;
            r_volt  <= $signed(s_axis_tdata[31:0]);
        end
    end

    lbvm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_idle     (seq_idle)
    );

    lbvm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_total       (r_total),
        .i_volt        (r_volt),
        .i_ocv_const   (r_ocv_const),
        .i_ocv_linear  (r_ocv_linear),
        .i_cap_recip   (r_cap_recip),
        .i_series_res  (r_series_res),
        .i_smooth_gain (r_smooth_gain),
        .i_charge_step (r_charge_step),
        .i_q_load      (q_load),
        .i_q_value     (i_cfg_data),
        .o_stat        (stat),
        .o_voltage     (dp_voltage),
        .o_charge      (dp_charge),
        .o_current     (dp_current)
    );

    // Output register: the final step stalls until the slot is free.
    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = ctrl.fire && (ctrl.op == OP_OUT || ctrl.op == OP_OUT_ZERO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {dp_current, dp_charge, dp_voltage};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/lbvm_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module lbvm_seq import lbvm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_idle
);

    localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] ST_ZERO = 4'd14;

    // control store: one word per step
    localparam t_uword ROM [NUM_STEPS] = '{
        '{OP_NOP,      MS_NONE,  COND_START,    ST_IDLE},  // wait for last load
        '{OP_DIV_INIT, MS_NONE,  COND_NEARZ,    ST_ZERO},  // load divider / bypass
        '{OP_DIV_STEP, MS_NONE,  COND_DIV,      ST_IDLE},  // one quotient bit
        '{OP_DIV_FIN,  MS_NONE,  COND_NEXT,     ST_IDLE},  // sign and saturate
        '{OP_NOP,      MS_KDIFF, COND_NEXT,     ST_IDLE},
        '{OP_F_UPD,    MS_NONE,  COND_NEXT,     ST_IDLE},
        '{OP_NOP,      MS_CSF,   COND_NEXT,     ST_IDLE},
        '{OP_Q_UPD,    MS_NONE,  COND_NEXT,     ST_IDLE},
        '{OP_NOP,      MS_QCAP,  COND_NEXT,     ST_IDLE},
        '{OP_D,        MS_NONE,  COND_NEXT,     ST_IDLE},
        '{OP_NOP,      MS_E1D,   COND_NEXT,     ST_IDLE},
        '{OP_T1,       MS_NONE,  COND_NEXT,     ST_IDLE},
        '{OP_NOP,      MS_RF,    COND_NEXT,     ST_IDLE},
        '{OP_OUT,      MS_NONE,  COND_OUT_WAIT, ST_IDLE},
        '{OP_OUT_ZERO, MS_NONE,  COND_OUT_WAIT, ST_IDLE},
        '{OP_NOP,      MS_NONE,  COND_JUMP,     ST_IDLE}
    };

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            word;

    assign word   = ROM[r_step];
    assign o_idle = (r_step == ST_IDLE);

    always_comb begin
        o_ctrl.op   = word.op;
        o_ctrl.msel = word.msel;
        o_ctrl.fire = (word.cond == COND_OUT_WAIT) ? i_out_free : 1'b1;
    end

    always_comb begin
        unique case (word.cond)
            COND_NEXT:     n_step = r_step + 1'b1;
            COND_START:    n_step = i_start ? r_step + 1'b1 : r_step;
            COND_NEARZ:    n_step = i_stat.near_zero ? word.target : r_step + 1'b1;
            COND_DIV:      n_step = i_stat.div_last ? r_step + 1'b1 : r_step;
            COND_OUT_WAIT: n_step = i_out_free ? word.target : r_step;
            COND_JUMP:     n_step = word.target;
            default:       n_step = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: rtl/lbvm_dp.sv
// Datapath: restoring divider, shared multiplier, filter and charge state.
module lbvm_dp import lbvm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  logic signed [SUM_W-1:0]  i_total,
    input  logic signed [DATA_W-1:0] i_volt,
    input  logic signed [DATA_W-1:0] i_ocv_const,
    input  logic signed [DATA_W-1:0] i_ocv_linear,
    input  logic [DATA_W-2:0]        i_cap_recip,
    input  logic [DATA_W-2:0]        i_series_res,
    input  logic [FRAC_W:0]          i_smooth_gain,
    input  logic [DATA_W-1:0]        i_charge_step,
    input  logic                     i_q_load,
    input  logic signed [DATA_W-1:0] i_q_value,
    output t_stat                    o_stat,
    output logic signed [DATA_W-1:0] o_voltage,
    output logic signed [DATA_W-1:0] o_charge,
    output logic signed [DATA_W-1:0] o_current
);

    logic [DATA_W-1:0]         r_rem;
    logic [DIV_BITS-1:0]       r_quo;
    logic [DATA_W-1:0]         r_dsor;
    logic                      r_neg;
    logic [DCNT_W-1:0]         r_cnt;
    logic signed [DATA_W-1:0]  r_tmp;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DATA_W-1:0]  r_f;
    logic signed [DATA_W-1:0]  r_q;

    logic [SUM_W-1:0]          mag_total;
    logic [DATA_W-1:0]         mag_volt;
    logic [DATA_W:0]           trial;
    logic                      ge;
    logic signed [DATA_W-1:0]  quo_sat;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-17:0] sh16;
    logic signed [PROD_W-33:0] sh32;
    logic signed [DATA_W-1:0]  u_sat;
    logic                      act;

    assign act = i_ctrl.fire;

    assign mag_total = i_total[SUM_W-1] ? SUM_W'(-i_total) : SUM_W'(i_total);
    assign mag_volt  = i_volt[DATA_W-1] ? DATA_W'(-i_volt) : DATA_W'(i_volt);

    assign o_stat.near_zero = (i_volt >= -DATA_W'(NEAR_ZERO)) && (i_volt <= DATA_W'(NEAR_ZERO));
    assign o_stat.div_last  = (r_cnt == DCNT_W'(1));

    // restoring division, one quotient bit per step
    assign trial = {r_rem, r_quo[DIV_BITS-1]};
    assign ge    = (trial >= {1'b0, r_dsor});

    always_comb begin
        if (!r_neg) begin
            if (r_quo > DIV_BITS'(64'h7FFF_FFFF)) begin
                quo_sat = 32'sh7FFF_FFFF;
            end else begin
                quo_sat = r_quo[DATA_W-1:0];
            end
        end else begin
            if (r_quo > DIV_BITS'(64'h8000_0000)) begin
                quo_sat = 32'sh8000_0000;
            end else begin
                quo_sat = -$signed(r_quo[DATA_W-1:0]);
            end
        end
    end

    // shared multiplier operand selection
    always_comb begin
        unique case (i_ctrl.msel)
            MS_KDIFF: begin
                mul_a = $signed({{(MUL_W-FRAC_W-1){1'b0}}, i_smooth_gain});
                mul_b = MUL_W'(r_tmp) - MUL_W'(r_f);
            end
            MS_CSF: begin
                mul_a = $signed({1'b0, i_charge_step});
                mul_b = MUL_W'(r_f);
            end
            MS_QCAP: begin
                mul_a = $signed({2'b00, i_cap_recip});
                mul_b = MUL_W'(r_q);
            end
            MS_E1D: begin
                mul_a = MUL_W'(i_ocv_linear);
                mul_b = MUL_W'(r_tmp);
            end
            MS_RF: begin
                mul_a = $signed({2'b00, i_series_res});
                mul_b = MUL_W'(r_f);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // floor shifts are plain slices of the signed product
    assign sh16  = r_prod[PROD_W-1:16];
    assign sh32  = r_prod[PROD_W-1:32];
    assign u_sat = sat32(WIDE_W'(sh16));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.msel != MS_NONE) begin
            r_prod <= n_prod;
        end
        if (act) begin
            unique case (i_ctrl.op)
                OP_DIV_INIT: begin
                    r_rem  <= '0;
                    r_quo  <= {mag_total, {FRAC_W{1'b0}}};
                    r_dsor <= mag_volt;
                    r_neg  <= i_total[SUM_W-1] ^ i_volt[DATA_W-1];
                end
                OP_DIV_STEP: begin
                    r_rem <= ge ? DATA_W'(trial - {1'b0, r_dsor}) : trial[DATA_W-1:0];
                    r_quo <= {r_quo[DIV_BITS-2:0], ge};
                end
                OP_DIV_FIN: r_tmp <= quo_sat;
                OP_D:       r_tmp <= sat32(WIDE_W'(65536) - WIDE_W'(u_sat));
                OP_T1:      r_acc <= ACC_W'(i_ocv_const) + ACC_W'(sh16);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (act && i_ctrl.op == OP_DIV_INIT) begin
            r_cnt <= DCNT_W'(DIV_BITS);
        end else if (act && i_ctrl.op == OP_DIV_STEP) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f <= '0;
            r_q <= '0;
        end else begin
            if (act && i_ctrl.op == OP_F_UPD) begin
                r_f <= sat32(WIDE_W'(r_f) + WIDE_W'(sh16));
            end
            if (i_q_load) begin
                r_q <= i_q_value;
            end else if (act && i_ctrl.op == OP_Q_UPD) begin
                r_q <= sat32(WIDE_W'(r_q) - WIDE_W'(sh32));
            end
        end
    end

    assign o_voltage = (i_ctrl.op == OP_OUT_ZERO) ? '0
                     : sat32(WIDE_W'(r_acc) - WIDE_W'(sh16));
    assign o_charge  = r_q;
    assign o_current = r_f;

endmodule
